[rtl/cte_pkg.sv]
// shared types and codes for the capability table engine
package cte_pkg;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_DERIVE  = 3'd1,
    CMD_CREATE  = 3'd2,
    CMD_REVOKE  = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_FIND    = 3'd5,
    CMD_SEND    = 3'd6,
    CMD_RECV    = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BOUNDS   = 4'd1,
    ST_NULL     = 4'd2,
    ST_TYPE     = 4'd3,
    ST_STALE    = 4'd4,
    ST_ACCESS   = 4'd5,
    ST_ESCAL    = 4'd6,
    ST_OCCUPIED = 4'd7,
    ST_POOL     = 4'd8,
    ST_BUSY     = 4'd9,
    ST_FULL     = 4'd10
  } status_t;

  localparam logic [1:0] TYPE_NULL     = 2'd0;
  localparam logic [1:0] TYPE_ENDPOINT = 2'd1;

  localparam logic [1:0] EP_IDLE      = 2'd0;
  localparam logic [1:0] EP_SEND_WAIT = 2'd1;
  localparam logic [1:0] EP_RECV_WAIT = 2'd2;

  localparam int CFG_SEND_MASK = 0;
  localparam int CFG_RECV_MASK = 1;

  // one decoded request as it waits in the queue
  typedef struct packed {
    cmd_t        command;
    logic [7:0]  slot_index;
    logic [7:0]  dest_index;
    logic [1:0]  cap_type;
    logic [7:0]  rights;
    logic [15:0] task_id;
    logic        s_oob;
    logic        d_oob;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  found_index;
    logic [1:0]  out_type;
    logic [7:0]  out_rights;
    logic [3:0]  out_endpoint;
    logic [15:0] wake_task;
    logic        caller_parked;
  } resp_t;

endpackage

[rtl/cte_front.sv]
// front end: takes requests, flags out-of-range slots, two-entry queue
module cte_front #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [44:0]     in_data,
  output logic            q_valid,
  input  logic            q_pop,
  output cte_pkg::req_t   q_req
);
  cte_pkg::req_t req_in;
  cte_pkg::req_t entry [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push;

  always_comb begin
    req_in.command    = cte_pkg::cmd_t'(in_data[2:0]);
    req_in.slot_index = in_data[10:3];
    req_in.dest_index = in_data[18:11];
    req_in.cap_type   = in_data[20:19];
    req_in.rights     = in_data[28:21];
    req_in.task_id    = in_data[44:29];
    req_in.s_oob      = 9'(in_data[10:3]) >= 9'(TABLE_SLOTS);
    req_in.d_oob      = 9'(in_data[18:11]) >= 9'(TABLE_SLOTS);
  end

  assign in_ready = count != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = count != 2'd0;
  assign q_req    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= req_in;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[rtl/cte_back.sv]
// back end: slot table and endpoint pool, read then write per request
module cte_back #(
  parameter int TABLE_SLOTS    = 64,
  parameter int POOL_ENDPOINTS = 16,
  parameter int RIGHTS_BITS    = 8,
  parameter int GEN_BITS       = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      send_right_mask,
  input  logic [7:0]      recv_right_mask,
  input  logic            q_valid,
  output logic            q_pop,
  input  cte_pkg::req_t   q_req,
  output logic            res_valid,
  input  logic            res_ready,
  output cte_pkg::resp_t  res
);
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int EW = (POOL_ENDPOINTS > 1) ? $clog2(POOL_ENDPOINTS) : 1;
  localparam int DW = RIGHTS_BITS + GEN_BITS + EW;

  typedef enum logic [0:0] {S_IDLE, S_EXEC} state_t;
  state_t state;

  // slot occupancy in flops, rights / generation / endpoint in a memory
  // a slot's memory word is read for every request, used only while occupied
  logic [TABLE_SLOTS-1:0] s_used;
  logic [DW-1:0]          s_mem   [TABLE_SLOTS];
  logic [DW-1:0]          s_rd;
  logic                   s_we;
  logic [SW-1:0]          s_waddr;
  logic [DW-1:0]          s_wdata;
  logic [SW-1:0]          s_raddr;

  logic [POOL_ENDPOINTS-1:0] e_used;
  logic [GEN_BITS-1:0]    e_gen   [POOL_ENDPOINTS];
  logic [1:0]             e_st    [POOL_ENDPOINTS];
  logic [15:0]            e_park  [POOL_ENDPOINTS];
  logic [15:0]            e_own   [POOL_ENDPOINTS];

  cte_pkg::req_t req;
  logic [SW-1:0] si, di;
  logic [1:0]  rt_type;
  logic [RIGHTS_BITS-1:0] rt_rgt;
  logic [GEN_BITS-1:0] rt_gen;
  logic [EW-1:0] rt_ep;
  logic [1:0] rd_type;
  logic stale;
  logic [7:0] need, rgt8;
  logic [1:0] want;
  cte_pkg::status_t chk;
  logic [EW-1:0] free_ep;
  logic free_found;
  logic [SW-1:0] slot_free;
  logic slot_found;
  logic [1:0] ep_st, park_st, meet_st;
  cte_pkg::resp_t res_next;
  logic do_derive, do_create, do_revoke, do_free, do_wake, do_park;

  assign si = req.slot_index[SW-1:0];
  assign di = req.dest_index[SW-1:0];
  assign s_raddr = q_req.slot_index[SW-1:0];
  assign rt_type = s_used[si] ? cte_pkg::TYPE_ENDPOINT : cte_pkg::TYPE_NULL;
  assign rt_rgt  = s_rd[DW-1 -: RIGHTS_BITS];
  assign rt_gen  = s_rd[EW +: GEN_BITS];
  assign rt_ep   = s_rd[EW-1:0];
  assign rd_type = s_used[di] ? cte_pkg::TYPE_ENDPOINT : cte_pkg::TYPE_NULL;
  assign stale   = (rt_type == cte_pkg::TYPE_ENDPOINT) && (e_gen[rt_ep] != rt_gen);
  assign rgt8    = 8'(rt_rgt);
  assign ep_st   = e_st[rt_ep];
  assign park_st = (req.command == cte_pkg::CMD_SEND) ?
                   cte_pkg::EP_SEND_WAIT : cte_pkg::EP_RECV_WAIT;
  assign meet_st = (req.command == cte_pkg::CMD_SEND) ?
                   cte_pkg::EP_RECV_WAIT : cte_pkg::EP_SEND_WAIT;
  // a result leaving this cycle frees the output register for the next request
  assign q_pop   = (state == S_IDLE) && q_valid && (!res_valid || res_ready);

  always_comb begin
    unique case (req.command)
      cte_pkg::CMD_SEND: begin need = send_right_mask; want = cte_pkg::TYPE_ENDPOINT; end
      cte_pkg::CMD_RECV: begin need = recv_right_mask; want = cte_pkg::TYPE_ENDPOINT; end
      default:           begin need = req.rights;      want = req.cap_type; end
    endcase
    if (req.s_oob) chk = cte_pkg::ST_BOUNDS;
    else if (rt_type == cte_pkg::TYPE_NULL) chk = cte_pkg::ST_NULL;
    else if (rt_type != want) chk = cte_pkg::ST_TYPE;
    else if (stale) chk = cte_pkg::ST_STALE;
    else if ((rgt8 & need) != need) chk = cte_pkg::ST_ACCESS;
    else chk = cte_pkg::ST_OK;
  end

  // lowest free pool entry
  always_comb begin
    free_ep = '0;
    free_found = 1'b0;
    for (int i = POOL_ENDPOINTS - 1; i >= 0; i--) begin
      if (!e_used[i]) begin
        free_ep = EW'(i);
        free_found = 1'b1;
      end
    end
  end

  // lowest null slot
  always_comb begin
    slot_free = '0;
    slot_found = 1'b0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!s_used[i]) begin
        slot_free = SW'(i);
        slot_found = 1'b1;
      end
    end
  end

  // result and update decisions for the request in execution
  always_comb begin
    res_next = '0;
    res_next.status = cte_pkg::ST_OK;
    do_derive = 1'b0;
    do_create = 1'b0;
    do_revoke = 1'b0;
    do_free   = 1'b0;
    do_wake   = 1'b0;
    do_park   = 1'b0;
    unique case (req.command)
      cte_pkg::CMD_LOOKUP: begin
        res_next.status = chk;
        if (chk == cte_pkg::ST_OK) begin
          res_next.out_type = rt_type;
          res_next.out_rights = rgt8;
          res_next.out_endpoint = 4'(rt_ep);
        end
      end
      cte_pkg::CMD_DERIVE: begin
        if (req.s_oob || req.d_oob) res_next.status = cte_pkg::ST_BOUNDS;
        else if (rt_type == cte_pkg::TYPE_NULL) res_next.status = cte_pkg::ST_NULL;
        else if (stale) res_next.status = cte_pkg::ST_STALE;
        else if ((req.rights & ~rgt8) != 8'd0) res_next.status = cte_pkg::ST_ESCAL;
        else if (rd_type != cte_pkg::TYPE_NULL) res_next.status = cte_pkg::ST_OCCUPIED;
        else do_derive = 1'b1;
      end
      cte_pkg::CMD_CREATE: begin
        if (req.s_oob) res_next.status = cte_pkg::ST_BOUNDS;
        else if (rt_type != cte_pkg::TYPE_NULL) res_next.status = cte_pkg::ST_OCCUPIED;
        else if (!free_found) res_next.status = cte_pkg::ST_POOL;
        else do_create = 1'b1;
      end
      cte_pkg::CMD_REVOKE: begin
        if (req.s_oob) res_next.status = cte_pkg::ST_BOUNDS;
        else if (rt_type != cte_pkg::TYPE_ENDPOINT) res_next.status = cte_pkg::ST_TYPE;
        else do_revoke = 1'b1;
      end
      cte_pkg::CMD_FREE: begin
        if (req.s_oob) res_next.status = cte_pkg::ST_BOUNDS;
        else do_free = 1'b1;
      end
      cte_pkg::CMD_FIND: begin
        if (slot_found) res_next.found_index = 6'(slot_free);
        else res_next.status = cte_pkg::ST_FULL;
      end
      cte_pkg::CMD_SEND, cte_pkg::CMD_RECV: begin
        if (chk != cte_pkg::ST_OK) res_next.status = chk;
        else if (ep_st == meet_st) begin
          do_wake = 1'b1;
          res_next.wake_task = e_park[rt_ep];
        end else if (ep_st == cte_pkg::EP_IDLE) begin
          do_park = 1'b1;
          res_next.caller_parked = req.task_id != 16'd0;
        end else res_next.status = cte_pkg::ST_BUSY;
      end
    endcase
  end

  assign s_we    = (state == S_EXEC) && (do_derive || do_create);
  assign s_waddr = do_create ? si : di;
  assign s_wdata = do_create ? {RIGHTS_BITS'(req.rights), {GEN_BITS{1'b0}}, free_ep}
                             : {RIGHTS_BITS'(req.rights), rt_gen, rt_ep};

  // slot memory, registered read addressed by the request being popped
  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_waddr] <= s_wdata;
    s_rd <= s_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      s_used <= '0;
      e_used <= '0;
      for (int i = 0; i < POOL_ENDPOINTS; i++) begin
        e_gen[i] <= '0;
        e_st[i] <= cte_pkg::EP_IDLE;
        e_park[i] <= '0;
        e_own[i] <= '0;
      end
    end else begin
      if (q_pop) req <= q_req;
      unique case (state)
        S_IDLE: begin
          if (res_valid && res_ready) res_valid <= 1'b0;
          if (q_pop) state <= S_EXEC;
        end
        S_EXEC: begin
          res <= res_next;
          res_valid <= 1'b1;
          state <= S_IDLE;
          if (do_derive) s_used[di] <= 1'b1;
          if (do_create) begin
            s_used[si] <= 1'b1;
            e_used[free_ep] <= 1'b1;
            e_gen[free_ep]  <= '0;
            e_st[free_ep]   <= cte_pkg::EP_IDLE;
            e_park[free_ep] <= '0;
            e_own[free_ep]  <= req.task_id;
          end
          if (do_free) s_used[si] <= 1'b0;
          if (do_revoke) e_gen[rt_ep] <= e_gen[rt_ep] + 1'b1;
          if (do_wake) begin
            e_st[rt_ep] <= cte_pkg::EP_IDLE;
            e_park[rt_ep] <= '0;
          end
          if (do_park) begin
            e_st[rt_ep] <= park_st;
            e_park[rt_ep] <= req.task_id;
          end
        end
      endcase
    end
  end
endmodule

[rtl/capability_table_engine.sv]
// top level of the capability table engine
// every command, find free included, passes the queue, the request register and the result register
// the back end takes a new request only in its idle state, after the last result is registered
// a result held by the sink stops the back end; the queue keeps taking requests until full
// a two-entry queue between front and back absorbs stalls on either side
// rst is synchronous: all slots read as null, pool clears, masks return to 1 and 2
module capability_table_engine #(
  parameter int TABLE_SLOTS    = 64,
  parameter int POOL_ENDPOINTS = 16,
  parameter int RIGHTS_BITS    = 8,
  parameter int GEN_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command, slot_index, dest_index, cap_type, rights, task_id (low first)
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, found_index, out_type, out_rights, out_endpoint, wake_task,
  // caller_parked (low first)
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [7:0] send_mask, recv_mask;
  logic q_valid, q_pop;
  cte_pkg::req_t q_req;
  cte_pkg::resp_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      send_mask <= 8'd1;
      recv_mask <= 8'd2;
    end else if (cfg_we) begin
      if (cfg_index == 1'(cte_pkg::CFG_SEND_MASK)) send_mask <= cfg_data;
      else recv_mask <= cfg_data;
    end
  end

  cte_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[44:0]),
    .q_valid, .q_pop, .q_req
  );

  cte_back #(
    .TABLE_SLOTS(TABLE_SLOTS), .POOL_ENDPOINTS(POOL_ENDPOINTS),
    .RIGHTS_BITS(RIGHTS_BITS), .GEN_BITS(GEN_BITS)
  ) u_back (
    .clk, .rst,
    .send_right_mask(send_mask), .recv_right_mask(recv_mask),
    .q_valid, .q_pop, .q_req,
    .res_valid(m_tvalid), .res_ready(m_tready), .res
  );

  // pack result fields, lowest first
  assign m_tdata = {7'd0, res.caller_parked, res.wake_task, res.out_endpoint,
                    res.out_rights, res.out_type, res.found_index, res.status};
endmodule

[rtl/cte_checker.sv]
// port-level checks for the capability table engine
module cte_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= 4'd10) else $error("bad status");
  a_park: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[40] |-> m_tdata[3:0] == 4'd0 && m_tdata[39:24] == 16'd0)
    else $error("park with wake");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind capability_table_engine cte_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
